@@ rtl/gws_pkg.sv @@
`timescale 1ns / 1ps
package gws_pkg;

  // Store sizes
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int MAX_WORD = 16;

  localparam int NUM_DIRS   = 8;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int KW         = $clog2(MAX_WORD);

  // Field widths fixed by the interface
  localparam int OP_W  = 2;
  localparam int FLD_W = 4;
  localparam int LET_W = 8;
  localparam int CFG_W = 5;
  localparam int CNT_W = 9;
  localparam int TOT_W = 12;
  localparam int IDX_W = 2;

  // Signed walk position: wide enough for start plus or minus a full word
  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ?
                           ((MAX_ROWS > MAX_WORD) ? MAX_ROWS : MAX_WORD) :
                           ((MAX_COLS > MAX_WORD) ? MAX_COLS : MAX_WORD);
  localparam int POS_W   = ($clog2(MAX_DIM) + 3 > FLD_W + 2) ?
                           $clog2(MAX_DIM) + 3 : FLD_W + 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(256);

  // Direction steps: right, down, left, up, down-right, up-right, down-left, up-left
  localparam logic signed [1:0] DIR_DR [NUM_DIRS] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                      2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] DIR_DC [NUM_DIRS] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                      2'sd1, 2'sd1, -2'sd1, -2'sd1};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_CELL   = 2'd0,
    OP_WRITE_LETTER = 2'd1,
    OP_PROBE        = 2'd2,
    OP_CLEAR        = 2'd3
  } opcode_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_GRID_ROWS   = 2'd0,
    CFG_GRID_COLS   = 2'd1,
    CFG_WORD_LENGTH = 2'd2
  } cfg_index_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic update;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_letter;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/gws_ram.sv @@
`timescale 1ns / 1ps
module gws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gws_ctrl.sv @@
`timescale 1ns / 1ps
module gws_ctrl
  import gws_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  opcode_e in_op_i,
  input  stat_t   stat_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Sequence one item: take it; for a probe walk the letters and settle counters; hand over the beat
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = (in_op_i == OP_PROBE) ? ST_RUN : ST_RESULT;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_letter) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/gws_dpath.sv @@
`timescale 1ns / 1ps
module gws_dpath
  import gws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  opcode_e          in_op_i,
  input  logic [FLD_W-1:0] in_row_i,
  input  logic [FLD_W-1:0] in_col_i,
  input  logic [FLD_W-1:0] in_pos_i,
  input  logic [LET_W-1:0] in_letter_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_mask_o,
  output logic [TOT_W-1:0] out_total_o,
  output logic [CNT_W-1:0] out_cnt_o [NUM_DIRS]
);

  function automatic int clamp_cfg(logic [CFG_W-1:0] v, int lo, int hi);
    int r;
    r = int'(v);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic [CFG_W-1:0] rows_q, cols_q, len_q;
  logic signed [POS_W-1:0] rows_eff, cols_eff, len_m1;
  logic [KW-1:0]    len_m1_k;

  opcode_e          op_q;
  logic [KW-1:0]    k_q;
  logic             word_we;
  logic [LET_W-1:0] word_rd;
  logic             cmp_v_q;

  logic signed [POS_W-1:0] pos_r_q [NUM_DIRS];
  logic signed [POS_W-1:0] pos_c_q [NUM_DIRS];
  logic signed [POS_W-1:0] start_r, start_c;
  logic signed [POS_W-1:0] end_r [NUM_DIRS];
  logic signed [POS_W-1:0] end_c [NUM_DIRS];
  logic [NUM_DIRS-1:0]     fit, ok_q, ok_d;
  logic                    inbound;

  logic                    grid_we;
  logic [GRID_AW-1:0]      grid_waddr;
  logic [GRID_AW-1:0]      grid_raddr [NUM_DIRS];
  logic [LET_W-1:0]        grid_rdata [NUM_DIRS];

  logic [CNT_W-1:0]        cnt_q [NUM_DIRS];
  logic [TOT_W-1:0]        total;
  logic                    out_valid_q;
  logic [7:0]              out_mask_q;
  logic [TOT_W-1:0]        out_total_q;
  logic [CNT_W-1:0]        out_cnt_q [NUM_DIRS];

  // Hold configuration; clamp on use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(16);
      cols_q <= CFG_W'(16);
      len_q  <= CFG_W'(2);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_GRID_ROWS)   rows_q <= cfg_data_i;
      if (cfg_index_i == CFG_GRID_COLS)   cols_q <= cfg_data_i;
      if (cfg_index_i == CFG_WORD_LENGTH) len_q  <= cfg_data_i;
    end
  end

  assign rows_eff = POS_W'(clamp_cfg(rows_q, 1, MAX_ROWS));
  assign cols_eff = POS_W'(clamp_cfg(cols_q, 1, MAX_COLS));
  assign len_m1   = POS_W'(clamp_cfg(len_q, 2, MAX_WORD) - 1);
  assign len_m1_k = KW'(clamp_cfg(len_q, 2, MAX_WORD) - 1);

  // Work out which directions keep the whole word inside the grid
  assign start_r = POS_W'(in_row_i);
  assign start_c = POS_W'(in_col_i);
  assign inbound = (start_r < rows_eff) && (start_c < cols_eff);

  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      end_r[d] = (DIR_DR[d] == 2'sd1) ? start_r + len_m1 :
                 (DIR_DR[d] == -2'sd1) ? start_r - len_m1 : start_r;
      end_c[d] = (DIR_DC[d] == 2'sd1) ? start_c + len_m1 :
                 (DIR_DC[d] == -2'sd1) ? start_c - len_m1 : start_c;
      fit[d]   = (end_r[d] >= 0) && (end_r[d] < rows_eff) &&
                 (end_c[d] >= 0) && (end_c[d] < cols_eff);
    end
  end

  // Grid copies: one per direction, all written together
  assign grid_we    = cmd_i.accept && (in_op_i == OP_WRITE_CELL) &&
                      (int'(in_row_i) < MAX_ROWS) && (int'(in_col_i) < MAX_COLS);
  assign grid_waddr = GRID_AW'(int'(in_row_i) * MAX_COLS + int'(in_col_i));

  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_dir
    assign grid_raddr[g] = GRID_AW'(int'(pos_r_q[g][ROW_W-1:0]) * MAX_COLS +
                                    int'(pos_c_q[g][COL_W-1:0]));
    gws_ram #(
      .WIDTH(LET_W),
      .DEPTH(GRID_DEPTH)
    ) u_grid (
      .clk_i  (clk_i),
      .we_i   (grid_we),
      .waddr_i(grid_waddr),
      .wdata_i(in_letter_i),
      .raddr_i(grid_raddr[g]),
      .rdata_o(grid_rdata[g])
    );
  end

  // Word letters; read alongside the grid so both arrive in the same cycle
  assign word_we = cmd_i.accept && (in_op_i == OP_WRITE_LETTER) &&
                   (int'(in_pos_i) < MAX_WORD);

  gws_ram #(
    .WIDTH(LET_W),
    .DEPTH(MAX_WORD)
  ) u_word (
    .clk_i  (clk_i),
    .we_i   (word_we),
    .waddr_i(KW'(in_pos_i)),
    .wdata_i(in_letter_i),
    .raddr_i(k_q),
    .rdata_o(word_rd)
  );

  // Walk positions and letter index
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= in_op_i;
      k_q  <= '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
        pos_r_q[d] <= start_r;
        pos_c_q[d] <= start_c;
      end
    end else if (cmd_i.issue) begin
      k_q <= k_q + KW'(1);
      for (int d = 0; d < NUM_DIRS; d++) begin
        pos_r_q[d] <= pos_r_q[d] + POS_W'(DIR_DR[d]);
        pos_c_q[d] <= pos_c_q[d] + POS_W'(DIR_DC[d]);
      end
    end
  end

  // Drop a direction on the first mismatching letter
  always_comb begin
    ok_d = ok_q;
    if (cmd_i.accept) begin
      ok_d = fit & {NUM_DIRS{inbound}};
    end else if (cmp_v_q) begin
      for (int d = 0; d < NUM_DIRS; d++) begin
        ok_d[d] = ok_q[d] && (grid_rdata[d] == word_rd);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q <= 1'b0;
      ok_q    <= '0;
    end else begin
      cmp_v_q <= cmd_i.issue;
      ok_q    <= ok_d;
    end
  end

  // Saturating direction counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_DIRS; d++) cnt_q[d] <= '0;
    end else if (cmd_i.accept && (in_op_i == OP_CLEAR)) begin
      for (int d = 0; d < NUM_DIRS; d++) cnt_q[d] <= '0;
    end else if (cmd_i.update) begin
      for (int d = 0; d < NUM_DIRS; d++) begin
        if (ok_q[d] && (cnt_q[d] < COUNT_MAX)) cnt_q[d] <= cnt_q[d] + CNT_W'(1);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int d = 0; d < NUM_DIRS; d++) total = total + TOT_W'(cnt_q[d]);
  end

  // Output register: holds the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mask_q  <= (op_q == OP_PROBE) ? ok_q : '0;
      out_total_q <= total;
      for (int d = 0; d < NUM_DIRS; d++) out_cnt_q[d] <= cnt_q[d];
    end
  end

  assign stat_o.last_letter = (k_q == len_m1_k);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_mask_o         = out_mask_q;
  assign out_total_o        = out_total_q;
  assign out_cnt_o          = out_cnt_q;

endmodule

@@ rtl/grid_word_search_eight_dir.sv @@
`timescale 1ns / 1ps
// Eight-direction word search. Load grid cells (opcode 0) and word letters (opcode 1), probe a
// start cell (opcode 2) or clear the counters (opcode 3); every input beat yields one result
// beat carrying the match mask and the saturating direction counters. For a probe the eight
// grid copies are read in parallel, one letter per cycle, so the letter walk sets its length;
// every other opcode skips the walk. The next input beat is taken as soon as the previous
// result sits in the output register. The grid and word stores are not cleared at reset;
// probing unwritten cells gives undefined results. Configuration is accepted in every
// cycle and should be written only while the block is idle.
module grid_word_search_eight_dir
  import gws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_row[3:0], cell_col[7:4], word_pos[11:8], letter[19:12], zero[23:20]
  input  logic [23:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // match_mask[7:0], total_matches[19:8], count_right[28:20], count_down[37:29],
  // count_left[46:38], count_up[55:47], count_down_right[64:56], count_up_right[73:65],
  // count_down_left[82:74], count_up_left[91:83], zero[95:92]
  output logic [95:0] m_axis_tdata
);

  cmd_t             cmd;
  stat_t            stat;
  opcode_e          in_op;
  logic [7:0]       out_mask;
  logic [TOT_W-1:0] out_total;
  logic [CNT_W-1:0] out_cnt [NUM_DIRS];

  assign cfg_ready_o = 1'b1;
  assign in_op       = opcode_e'(s_axis_tuser);

  gws_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (in_op),
    .stat_i    (stat),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd)
  );

  gws_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_op_i    (in_op),
    .in_row_i   (s_axis_tdata[3:0]),
    .in_col_i   (s_axis_tdata[7:4]),
    .in_pos_i   (s_axis_tdata[11:8]),
    .in_letter_i(s_axis_tdata[19:12]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_mask_o (out_mask),
    .out_total_o(out_total),
    .out_cnt_o  (out_cnt)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0000, out_cnt[7], out_cnt[6], out_cnt[5], out_cnt[4],
                         out_cnt[3], out_cnt[2], out_cnt[1], out_cnt[0], out_total, out_mask};

`ifndef SYNTHESIS
  // One item at a time: no second beat taken right after one is accepted
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still in flight");

  // Total must equal the sum of the counters it is sent with
  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19:8] ==
      12'(m_axis_tdata[28:20]) + 12'(m_axis_tdata[37:29]) + 12'(m_axis_tdata[46:38]) +
      12'(m_axis_tdata[55:47]) + 12'(m_axis_tdata[64:56]) + 12'(m_axis_tdata[73:65]) +
      12'(m_axis_tdata[82:74]) + 12'(m_axis_tdata[91:83])))
    else $error("total does not match direction counters");

  // A reported match to the right must show in its counter
  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[28:20] != 9'd0))
    else $error("match reported to the right with zero counter");
`endif

endmodule

@@ sim/grid_word_search_eight_dir_tb.sv @@
`timescale 1ns / 1ps
module grid_word_search_eight_dir_tb;
  import gws_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 2 * MAX_WORD + 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_PRINTED   = 40;
  localparam int SAT_PROBES    = 270;
  localparam int HOLD_OFF      = 300;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Input beat: row, col, word position, letter from the lowest bit up
  typedef struct packed {
    logic [3:0]       pad;
    logic [LET_W-1:0] letter;
    logic [FLD_W-1:0] pos;
    logic [FLD_W-1:0] col;
    logic [FLD_W-1:0] row;
  } in_beat_t;

  // Result beat: mask, total, then the eight counters in direction order
  typedef struct packed {
    logic [3:0]                     pad;
    logic [NUM_DIRS-1:0][CNT_W-1:0] counts;
    logic [TOT_W-1:0]               total;
    logic [NUM_DIRS-1:0]            mask;
  } result_t;

  // One row of the directed table; known marks a result of all zeros
  typedef struct packed {
    opcode_e          op;
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
    logic [FLD_W-1:0] pos;
    logic [LET_W-1:0] letter;
    logic             known;
  } directed_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i   = CFG_GRID_ROWS;
  logic [CFG_W-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;
  logic [OP_W-1:0]   s_axis_tuser  = OP_WRITE_CELL;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;

  // Shadow of the block: stores, counters and raw register values
  logic [LET_W-1:0] grid_cells [MAX_ROWS][MAX_COLS];
  logic [LET_W-1:0] word_letters [MAX_WORD];
  int               dir_hits [NUM_DIRS];
  int               rows_reg = 16;
  int               cols_reg = 16;
  int               len_reg  = 2;

  // Direction steps: right, down, left, up, down-right, up-right, down-left, up-left
  int step_r [NUM_DIRS] = '{0, 1, 0, -1, 1, -1, 1, -1};
  int step_c [NUM_DIRS] = '{1, 0, -1, 0, 1, 1, -1, -1};
  string count_names [NUM_DIRS] = '{"count_right", "count_down", "count_left", "count_up",
                                    "count_down_right", "count_up_right", "count_down_left",
                                    "count_up_left"};

  result_t mask_and_counts_q [$];
  int      errors      = 0;
  int      sent_beats  = 0;
  int      cycle_count = 0;
  int      hold_cycles = 0;
  bit      src_idle_en = 1'b0;
  bit      snk_idle_en = 1'b0;

  directed_row_t directed [21] = '{
    '{OP_CLEAR,        4'h0, 4'h0, 4'h0, 8'h00, 1'b1},
    '{OP_WRITE_CELL,   4'h0, 4'h0, 4'hF, 8'h00, 1'b1},
    '{OP_WRITE_CELL,   4'h0, 4'h1, 4'h0, 8'h00, 1'b1},
    '{OP_WRITE_CELL,   4'h1, 4'h0, 4'hF, 8'h00, 1'b1},
    '{OP_WRITE_CELL,   4'h1, 4'h1, 4'h0, 8'h00, 1'b1},
    '{OP_WRITE_LETTER, 4'hF, 4'hF, 4'h0, 8'h00, 1'b1},
    '{OP_WRITE_LETTER, 4'h0, 4'h0, 4'h1, 8'h00, 1'b1},
    '{OP_PROBE,        4'h0, 4'h0, 4'hF, 8'hFF, 1'b0},
    '{OP_WRITE_CELL,   4'hF, 4'hF, 4'h0, 8'hFF, 1'b0},
    '{OP_WRITE_CELL,   4'hF, 4'hE, 4'hF, 8'hFF, 1'b0},
    '{OP_WRITE_CELL,   4'hE, 4'hF, 4'h0, 8'hFF, 1'b0},
    '{OP_WRITE_CELL,   4'hE, 4'hE, 4'hF, 8'hFF, 1'b0},
    '{OP_WRITE_LETTER, 4'h0, 4'hF, 4'h0, 8'hFF, 1'b0},
    '{OP_WRITE_LETTER, 4'hF, 4'h0, 4'h1, 8'hFF, 1'b0},
    '{OP_PROBE,        4'hF, 4'hF, 4'h0, 8'h00, 1'b0},
    '{OP_PROBE,        4'h0, 4'hF, 4'hF, 8'h00, 1'b0},
    '{OP_PROBE,        4'hF, 4'h0, 4'h0, 8'hFF, 1'b0},
    '{OP_WRITE_LETTER, 4'hF, 4'hF, 4'hF, 8'hFF, 1'b0},
    '{OP_PROBE,        4'h0, 4'h0, 4'h0, 8'h00, 1'b0},
    '{OP_CLEAR,        4'hF, 4'hF, 4'hF, 8'hFF, 1'b1},
    '{OP_WRITE_LETTER, 4'h0, 4'h0, 4'hF, 8'h00, 1'b1}
  };

  grid_word_search_eight_dir dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int clamp_dim(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly a three-letter alphabet so that words turn up; now and then any code
  function automatic logic [LET_W-1:0] pick_letter();
    logic [LET_W-1:0] v;
    v = LET_W'($urandom);
    if ($urandom_range(0, 4) != 0) v = 8'h41 + LET_W'($urandom_range(0, 2));
    return v;
  endfunction

  // Apply one beat to the shadow state and return the result it yields
  function automatic result_t search_step(opcode_e op, logic [FLD_W-1:0] row,
                                          logic [FLD_W-1:0] col, logic [FLD_W-1:0] pos,
                                          logic [LET_W-1:0] letter);
    result_t res;
    int      nr, nc, nl, r0, c0, er, ec, sum;
    bit      hit;
    res = '0;
    nr  = clamp_dim(rows_reg, 1, MAX_ROWS);
    nc  = clamp_dim(cols_reg, 1, MAX_COLS);
    nl  = clamp_dim(len_reg, 2, MAX_WORD);
    r0  = int'(row);
    c0  = int'(col);
    case (op)
      OP_WRITE_CELL:   grid_cells[r0][c0] = letter;
      OP_WRITE_LETTER: word_letters[int'(pos)] = letter;
      OP_PROBE: begin
        if (r0 < nr && c0 < nc) begin
          for (int d = 0; d < NUM_DIRS; d++) begin
            // Word must end inside the grid in use, then every letter must agree
            er  = r0 + step_r[d] * (nl - 1);
            ec  = c0 + step_c[d] * (nl - 1);
            hit = (er >= 0) && (er < nr) && (ec >= 0) && (ec < nc);
            for (int k = 0; k < nl && hit; k++) begin
              if (grid_cells[r0 + step_r[d] * k][c0 + step_c[d] * k] != word_letters[k])
                hit = 1'b0;
            end
            if (hit) begin
              res.mask[d] = 1'b1;
              if (dir_hits[d] < int'(COUNT_MAX)) dir_hits[d]++;
            end
          end
        end
      end
      default: foreach (dir_hits[d]) dir_hits[d] = 0;
    endcase
    sum = 0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      res.counts[d] = CNT_W'(dir_hits[d]);
      sum += dir_hits[d];
    end
    res.total = TOT_W'(sum);
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, field, got, want);
  endtask

  // Offer one beat, after a random gap if source idling is on; on acceptance log its result
  task automatic send_beat(opcode_e op, logic [FLD_W-1:0] row, logic [FLD_W-1:0] col,
                           logic [FLD_W-1:0] pos, logic [LET_W-1:0] letter,
                           bit known_zero = 1'b0);
    in_beat_t beat;
    result_t  res;
    int       gap;
    beat        = '0;
    beat.row    = row;
    beat.col    = col;
    beat.pos    = pos;
    beat.letter = letter;
    gap = src_idle_en ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = search_step(op, row, col, pos, letter);
    // Rows with a typed result check against zeros
    if (known_zero) res = '0;
    mask_and_counts_q.push_back(res);
    sent_beats++;
  endtask

  // Stop offering and let every result come home, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mask_and_counts_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setting(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                               logic [CFG_W-1:0] len, bit poke_unused);
    logic [IDX_W-1:0] idxs [4];
    logic [CFG_W-1:0] vals [4];
    int               n;
    idxs[0] = CFG_GRID_ROWS;
    idxs[1] = CFG_GRID_COLS;
    idxs[2] = CFG_WORD_LENGTH;
    idxs[3] = CFG_UNUSED_IDX;
    vals[0] = rows;
    vals[1] = cols;
    vals[2] = len;
    vals[3] = CFG_W'($urandom);
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idxs[i])
        CFG_GRID_ROWS:   rows_reg = int'(vals[i]);
        CFG_GRID_COLS:   cols_reg = int'(vals[i]);
        CFG_WORD_LENGTH: len_reg  = int'(vals[i]);
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One setting: planted words probed at their start in 35 of 100 picks where they fit, the rest random traffic
  task automatic run_phase(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                           logic [CFG_W-1:0] len, int n, bit idle, int hold, bit poke);
    int first, nr, nc, nl, d, lo_r, hi_r, lo_c, hi_c, r0, c0, bad, pick;
    drain();
    write_setting(rows, cols, len, poke);
    src_idle_en = idle && ($urandom_range(0, 3) != 0);
    snk_idle_en = idle && ($urandom_range(0, 3) != 0);
    hold_cycles = hold;
    nr    = clamp_dim(rows_reg, 1, MAX_ROWS);
    nc    = clamp_dim(cols_reg, 1, MAX_COLS);
    nl    = clamp_dim(len_reg, 2, MAX_WORD);
    first = sent_beats;
    while (sent_beats - first < n) begin
      d    = $urandom_range(0, NUM_DIRS - 1);
      lo_r = (step_r[d] < 0) ? nl - 1 : 0;
      hi_r = (step_r[d] > 0) ? nr - nl : nr - 1;
      lo_c = (step_c[d] < 0) ? nl - 1 : 0;
      hi_c = (step_c[d] > 0) ? nc - nl : nc - 1;
      if ($urandom_range(0, 99) < 35 && lo_r <= hi_r && lo_c <= hi_c) begin
        r0 = $urandom_range(hi_r, lo_r);
        c0 = $urandom_range(hi_c, lo_c);
        if ($urandom_range(0, 1) != 0) begin
          for (int k = 0; k < nl; k++)
            send_beat(OP_WRITE_LETTER, FLD_W'($urandom), FLD_W'($urandom), FLD_W'(k),
                      pick_letter());
        end
        // Lay the word along the direction, now and then with one letter spoilt
        bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nl - 1) : -1;
        for (int k = 0; k < nl; k++)
          send_beat(OP_WRITE_CELL, FLD_W'(r0 + step_r[d] * k), FLD_W'(c0 + step_c[d] * k),
                    FLD_W'($urandom),
                    (k == bad) ? word_letters[k] ^ 8'h01 : word_letters[k]);
        send_beat(OP_PROBE, FLD_W'(r0), FLD_W'(c0), FLD_W'($urandom), LET_W'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          send_beat(OP_PROBE,
                    FLD_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, nr - 1) : $urandom),
                    FLD_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, nc - 1) : $urandom),
                    FLD_W'($urandom), LET_W'($urandom));
        else if (pick < 65)
          send_beat(OP_WRITE_CELL, FLD_W'($urandom), FLD_W'($urandom), FLD_W'($urandom),
                    pick_letter());
        else if (pick < 96)
          send_beat(OP_WRITE_LETTER, FLD_W'($urandom), FLD_W'($urandom), FLD_W'($urandom),
                    pick_letter());
        else
          send_beat(OP_CLEAR, FLD_W'($urandom), FLD_W'($urandom), FLD_W'($urandom),
                    LET_W'($urandom));
      end
    end
  endtask

  // Check each result beat against the oldest pending one
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (mask_and_counts_q.size() == 0) begin
        report_mismatch("unrequested result, match_mask", int'(got.mask), 0);
      end else begin
        want = mask_and_counts_q.pop_front();
        if (got.mask !== want.mask)
          report_mismatch("match_mask", int'(got.mask), int'(want.mask));
        if (got.total !== want.total)
          report_mismatch("total_matches", int'(got.total), int'(want.total));
        for (int d = 0; d < NUM_DIRS; d++) begin
          if (got.counts[d] !== want.counts[d])
            report_mismatch(count_names[d], int'(got.counts[d]), int'(want.counts[d]));
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = snk_idle_en ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    foreach (dir_hits[d]) dir_hits[d] = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill both stores so that no probe can read an unwritten entry
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        send_beat(OP_WRITE_CELL, FLD_W'(r), FLD_W'(c), FLD_W'($urandom), pick_letter(),
                  1'b1);
    for (int k = 0; k < MAX_WORD; k++)
      send_beat(OP_WRITE_LETTER, FLD_W'($urandom), FLD_W'($urandom), FLD_W'(k),
                pick_letter(), 1'b1);

    // Directed rows: corners, letter extremes, every opcode
    foreach (directed[i])
      send_beat(directed[i].op, directed[i].row, directed[i].col, directed[i].pos,
                directed[i].letter, directed[i].known);

    // Saturate every counter: a uniform block probed at its centre hits all directions
    drain();
    write_setting(5'd16, 5'd16, 5'd2, 1'b1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_beat(OP_WRITE_CELL, FLD_W'(r), FLD_W'(c), FLD_W'($urandom), 8'h5A);
    send_beat(OP_WRITE_LETTER, FLD_W'($urandom), FLD_W'($urandom), 4'd0, 8'h5A);
    send_beat(OP_WRITE_LETTER, FLD_W'($urandom), FLD_W'($urandom), 4'd1, 8'h5A);
    for (int i = 0; i < SAT_PROBES; i++)
      send_beat(OP_PROBE, 4'd1, 4'd1, FLD_W'($urandom), LET_W'($urandom));
    send_beat(OP_CLEAR, FLD_W'($urandom), FLD_W'($urandom), FLD_W'($urandom),
              LET_W'($urandom));

    // Settings from the extremes inwards, including out-of-range values that clamp
    run_phase(5'd16, 5'd16, 5'd16, 50, 1'b1, 0, 1'b0);
    run_phase(5'd1,  5'd1,  5'd2,  40, 1'b1, 0, 1'b1);
    run_phase(5'd1,  5'd16, 5'd16, 50, 1'b1, 0, 1'b0);
    run_phase(5'd16, 5'd1,  5'd16, 50, 1'b1, 0, 1'b0);
    run_phase(5'd0,  5'd0,  5'd0,  30, 1'b1, 0, 1'b1);
    run_phase(5'd31, 5'd31, 5'd31, 50, 1'b1, HOLD_OFF, 1'b0);
    run_phase(5'd4,  5'd5,  5'd3,  50, 1'b0, 0, 1'b0);
    run_phase(5'd7,  5'd9,  5'd5,  50, 1'b1, 0, 1'b1);
    for (int i = 0; i < 2; i++)
      run_phase(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)),
                CFG_W'($urandom_range(2, 16)), 50, 1'b1, 0, 1'b0);

    drain();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
